// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/u16u8_pkg.sv =====
package u16u8_pkg;

    // Error codes carried on the result channel.
    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_LONE_LOW    = 2'd1,
        ERR_HIGH_NO_LOW = 2'd2,
        ERR_HIGH_AT_END = 2'd3
    } err_kind_t;

    // Surrogate prefixes: the top six bits of a code unit.
    localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
    localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;

    // Code point limits for the UTF-8 length classes.
    localparam logic [20:0] CP_ONE_BYTE_LIMIT = 21'h00080;
    localparam logic [20:0] CP_TWO_BYTE_LIMIT = 21'h00800;
    localparam logic [20:0] CP_SUPP_BASE      = 21'h10000;

    // UTF-8 lead and continuation markers.
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    // Up to four bytes, first byte in slot 0, and the slot of the last byte.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } u8_seq_t;

    // Encode one code point into its UTF-8 byte sequence.
    function automatic u8_seq_t encode_cp(input logic [20:0] cp);
        u8_seq_t seq;
        seq = '0;
        if (cp < CP_ONE_BYTE_LIMIT) begin
            seq.bytes[0] = {1'b0, cp[6:0]};
            seq.last_idx = 2'd0;
        end else if (cp < CP_TWO_BYTE_LIMIT) begin
            seq.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            seq.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            seq.last_idx = 2'd1;
        end else if (cp < CP_SUPP_BASE) begin
            seq.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            seq.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            seq.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            seq.last_idx = 2'd2;
        end else begin
            seq.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            seq.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            seq.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            seq.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            seq.last_idx = 2'd3;
        end
        return seq;
    endfunction

endpackage

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// The first byte of an item is registered and shown in the cycle after the item's input beat.
// An item yields 1 to 4 bytes, one per output beat, and holds the output until its last byte
// leaves; the next item is taken in the cycle that its predecessor's last byte leaves.
// Items that yield no byte (held high surrogate, dropped units) do not occupy the output buffer.
// Reset (aresetn low, synchronous) clears the byte order, surrogate and drop state
// and empties the output buffer.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_string_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_utf8_byte,
    output logic        m_run_last,
    output logic [1:0]  m_error_kind,
    output logic        m_string_done
);

    // Configuration and decoder state.
    logic        big_endian_reg;
    logic [9:0]  held_high_reg, held_high_next;
    logic        high_pending_reg, high_pending_next;
    logic        dropping_reg, dropping_next;

    // Output buffer holding the byte sequence of one item.
    logic            buf_valid_reg, buf_valid_next;
    logic [3:0][7:0] bytes_reg, bytes_next;
    logic [1:0]      last_idx_reg, last_idx_next;
    logic [1:0]      idx_reg, idx_next;
    err_kind_t       err_reg, err_next;
    logic            done_reg, done_next;

    logic        in_beat;
    logic        out_beat;
    logic        out_last;
    logic [15:0] unit;
    logic        is_high;
    logic        is_low;
    logic        load;
    u8_seq_t     seq;
    err_kind_t   err_kind;
    logic [20:0] cp;

    // Handshake: a new item enters when the buffer is free or drains this cycle.
    assign out_last = (idx_reg == last_idx_reg);
    assign out_beat = buf_valid_reg && m_ready;
    assign s_ready  = !buf_valid_reg || (m_ready && out_last);
    assign in_beat  = s_valid && s_ready;

    // Byte order and surrogate classification of the incoming unit.
    assign unit    = big_endian_reg ? {s_code_unit[7:0], s_code_unit[15:8]} : s_code_unit;
    assign is_high = (unit[15:10] == HIGH_SURR_PREFIX);
    assign is_low  = (unit[15:10] == LOW_SURR_PREFIX);

    // Decode one unit against the held state and build its byte sequence.
    always_comb begin
        held_high_next    = held_high_reg;
        high_pending_next = high_pending_reg;
        dropping_next     = dropping_reg;
        load              = 1'b0;
        err_kind          = ERR_NONE;
        cp                = {5'd0, unit};
        seq               = encode_cp(cp);
        if (in_beat) begin
            if (dropping_reg) begin
                if (s_string_end) begin
                    dropping_next     = 1'b0;
                    high_pending_next = 1'b0;
                    held_high_next    = '0;
                end
            end else if (high_pending_reg) begin
                high_pending_next = 1'b0;
                held_high_next    = '0;
                load              = 1'b1;
                if (is_low) begin
                    cp  = {1'b0, held_high_reg, unit[9:0]} + CP_SUPP_BASE;
                    seq = encode_cp(cp);
                end else begin
                    err_kind      = ERR_HIGH_NO_LOW;
                    dropping_next = !s_string_end;
                end
            end else if (is_high) begin
                if (s_string_end) begin
                    load     = 1'b1;
                    err_kind = ERR_HIGH_AT_END;
                end else begin
                    held_high_next    = unit[9:0];
                    high_pending_next = 1'b1;
                end
            end else if (is_low) begin
                load          = 1'b1;
                err_kind      = ERR_LONE_LOW;
                dropping_next = !s_string_end;
            end else begin
                load = 1'b1;
            end
            // Error results carry a single zero byte.
            if (err_kind != ERR_NONE) begin
                seq = '0;
            end
        end
    end

    // Output buffer: load a new sequence or step to the next byte.
    always_comb begin
        buf_valid_next = buf_valid_reg;
        bytes_next     = bytes_reg;
        last_idx_next  = last_idx_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        done_next      = done_reg;
        if (load) begin
            buf_valid_next = 1'b1;
            bytes_next     = seq.bytes;
            last_idx_next  = seq.last_idx;
            idx_next       = '0;
            err_next       = err_kind;
            done_next      = s_string_end;
        end else if (out_beat) begin
            if (out_last) begin
                buf_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg   <= 1'b0;
            held_high_reg    <= '0;
            high_pending_reg <= 1'b0;
            dropping_reg     <= 1'b0;
            buf_valid_reg    <= 1'b0;
            idx_reg          <= '0;
        end else begin
            if (cfg_we) begin
                big_endian_reg <= cfg_wdata;
            end
            held_high_reg    <= held_high_next;
            high_pending_reg <= high_pending_next;
            dropping_reg     <= dropping_next;
            buf_valid_reg    <= buf_valid_next;
            idx_reg          <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        bytes_reg    <= bytes_next;
        last_idx_reg <= last_idx_next;
        err_reg      <= err_next;
        done_reg     <= done_next;
    end

    // Result channel.
    assign m_valid       = buf_valid_reg;
    assign m_utf8_byte   = bytes_reg[idx_reg];
    assign m_run_last    = out_last;
    assign m_error_kind  = err_reg;
    assign m_string_done = done_reg && out_last;

endmodule

// ===== rtl/core/u16u8_checker.sv =====
`include "assert_macros.svh"

module u16u8_checker
    import u16u8_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_utf8_byte,
    input logic        m_run_last,
    input logic [1:0]  m_error_kind,
    input logic        m_string_done
);

    // A stalled output beat keeps its payload.
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_utf8_byte) && $stable(m_run_last) && $stable(m_error_kind) && $stable(m_string_done), "stalled output beat changed")

    // Error results are a single zero byte.
    `ASSERT_CLK_RST(a_err_single, aclk, aresetn, m_valid && (m_error_kind != ERR_NONE) |-> (m_utf8_byte == 8'd0) && m_run_last, "error result is not a lone zero byte")

    // The string only ends on the last byte of an item.
    `ASSERT_CLK_RST(a_done_last, aclk, aresetn, m_valid && m_string_done |-> m_run_last, "string end before last byte")

    // A byte after a non-last byte follows at once and is a continuation byte.
    `ASSERT_CLK_RST(a_cont_next, aclk, aresetn, m_valid && m_ready && !m_run_last |=> m_valid && (m_utf8_byte[7:6] == 2'b10), "missing continuation byte")

    // Reset empties the output.
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);
